// File: rtl/core/gcb_pkg.sv
// Shared types, constants and helpers for the gray convert / center mean / binarize block.
// No dependencies; imported by the interface users, the top level and the checker.
`default_nettype none

package gcb_pkg;

  localparam int DIM_W      = 13;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 31;
  localparam int CNT_W      = 23;
  localparam int ACC_W      = 24;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // Luma weights 0.2989, 0.587, 0.114 with 16 fraction bits
  localparam logic [WEIGHT_W-1:0] WEIGHT_R = 16'd19588;
  localparam logic [WEIGHT_W-1:0] WEIGHT_G = 16'd38470;
  localparam logic [WEIGHT_W-1:0] WEIGHT_B = 16'd7471;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  localparam logic [1:0] OP_PIXEL    = 2'd0;
  localparam logic [1:0] OP_EOF      = 2'd1;
  localparam logic [1:0] OP_BINARIZE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] gray_value;
  } gcb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [PIX_W-1:0] mean_out;
    logic             mean_valid;
  } gcb_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } gcb_cfg_t;

  // Weight for luma step 0 (red), 1 (green), 2 (blue)
  function automatic logic [WEIGHT_W-1:0] luma_weight(input logic [1:0] k);
    logic [WEIGHT_W-1:0] w;
    case (k)
      2'd0:    w = WEIGHT_R;
      2'd1:    w = WEIGHT_G;
      default: w = WEIGHT_B;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gcb_stream_if.sv
// Valid/ready channel carrying one payload of type T per transaction.
// Depends on nothing; payload types come from gcb_pkg at instantiation.
`default_nettype none

interface gcb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gray_convert_center_mean_binarize_top.sv
// Top level of the gray convert / center mean / binarize block.
// Depends on gcb_pkg and gcb_stream_if.
//
// Channels: in_ch (sink, gcb_in_t) takes one item per transaction; out_ch
// (source, gcb_out_t) returns exactly one result per item; cfg_ch (sink,
// gcb_cfg_t) writes image_width (index 0) or image_height (index 1). Config
// is always ready and must be written only while the block is idle.
// Steps from input transaction to result valid:
//   colour pixel   3 multiply-accumulate steps, window update, output
//   end of frame   with a non-empty window, a 31-step restoring divide
//                  and then output; straight to output with an empty one
//   binarize/other straight to output
// One item is in work at a time; in_ch.ready is high only in the idle state,
// so the next item is taken only after the previous one has left the
// sequencer for the output register. A new item can
// be taken while the previous result still waits in the output register.
// Reset (rst_n low, synchronous) restores width 640, height 480, clears the
// position, accumulators and latched mean, and empties the output register.
// If out_ch.ready is low, the finished result waits in the output stage and
// the next one holds in the sequencer until the register frees.
`default_nettype none

module gray_convert_center_mean_binarize_top #(
  parameter int MAX_DIM = gcb_pkg::MAX_DIM_DEFAULT
) (
  input  wire          clk,
  input  wire          rst_n,
  gcb_stream_if.sink   in_ch,
  gcb_stream_if.source out_ch,
  gcb_stream_if.sink   cfg_ch
);
  import gcb_pkg::*;

  localparam logic [DIM_W:0] MaxDim = (DIM_W+1)'(MAX_DIM);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LUMA   = 3'd1;
  localparam logic [2:0] S_ACCUM  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [4:0] DivLast = 5'(SUM_W - 1);

  function automatic logic [DIM_W:0] eff_dim(input logic [DIM_W-1:0] v);
    return ({1'b0, v} > MaxDim) ? MaxDim : {1'b0, v};
  endfunction

  logic [2:0]        state_r;
  logic [4:0]        step_r;
  logic [DIM_W-1:0]  width_r, height_r;
  logic [DIM_W-1:0]  col_r, row_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PIX_W-1:0]  mean_r;
  logic              flag_r;
  logic [PIX_W-1:0]  red_r, green_r, blue_r;
  logic [ACC_W-1:0]  acc_r;
  logic [PIX_W-1:0]  pix_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  divisor_r;
  logic              out_valid_r;
  gcb_out_t          out_data_r;

  logic              in_fire, cfg_fire;
  logic [PIX_W-1:0]  comp;
  logic [ACC_W-1:0]  prod;
  logic [PIX_W-1:0]  luma;
  logic [DIM_W-1:0]  col_inc;
  logic [DIM_W:0]    w_eff, h_eff;
  logic [DIM_W+1:0]  w_lo, w_hi, h_lo, h_hi;
  logic              col_in, row_in;
  logic [SUM_W:0]    sum_add;
  logic [CNT_W:0]    trial;
  logic [CNT_W+1:0]  diff;
  logic              no_borrow;
  logic [SUM_W-1:0]  quo_nxt;
  logic [CNT_W-1:0]  rem_nxt;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid;

  // Shared multiply-accumulate: one weight times one component per step
  always_comb begin
    case (step_r[1:0])
      2'd0:    comp = red_r;
      2'd1:    comp = green_r;
      default: comp = blue_r;
    endcase
    prod = ACC_W'(luma_weight(step_r[1:0])) * ACC_W'(comp);
  end

  assign luma = acc_r[ACC_W-1 -: PIX_W];

  // Window test on the already-incremented column
  always_comb begin
    w_eff   = eff_dim(width_r);
    h_eff   = eff_dim(height_r);
    col_inc = col_r + 1'b1;
    w_lo    = (DIM_W+2)'(w_eff >> 2);
    w_hi    = ((DIM_W+2)'(w_eff) + ((DIM_W+2)'(w_eff) << 1)) >> 2;
    h_lo    = (DIM_W+2)'(h_eff >> 2);
    h_hi    = ((DIM_W+2)'(h_eff) + ((DIM_W+2)'(h_eff) << 1)) >> 2;
    col_in  = ((DIM_W+2)'(col_inc) >= w_lo) && ((DIM_W+2)'(col_inc) <= w_hi);
    row_in  = ((DIM_W+2)'(row_r) >= h_lo) && ((DIM_W+2)'(row_r) <= h_hi);
    sum_add = (SUM_W+1)'(sum_r) + (SUM_W+1)'(luma);
  end

  // Restoring divide step: shift in one dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem_r, quo_r[SUM_W-1]};
    diff      = (CNT_W+2)'(trial) - (CNT_W+2)'(divisor_r);
    no_borrow = ~diff[CNT_W+1];
    // the remainder always stays below the divisor
    rem_nxt   = no_borrow ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    quo_nxt   = {quo_r[SUM_W-2:0], no_borrow};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= DIM_W'(eff_dim(HEIGHT_RESET));
      sum_r       <= '0;
      cnt_r       <= '0;
      mean_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_fire) begin
        case (cfg_ch.data.index)
          REG_IMAGE_WIDTH: begin
            width_r <= cfg_ch.data.data[DIM_W-1:0];
          end
          REG_IMAGE_HEIGHT: begin
            height_r <= cfg_ch.data.data[DIM_W-1:0];
            row_r    <= DIM_W'(eff_dim(cfg_ch.data.data[DIM_W-1:0]));
          end
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.data.opcode)
              OP_PIXEL: begin
                red_r   <= in_ch.data.red;
                green_r <= in_ch.data.green;
                blue_r  <= in_ch.data.blue;
                acc_r   <= '0;
                step_r  <= '0;
                state_r <= S_LUMA;
              end
              OP_EOF: begin
                pix_r     <= '0;
                flag_r    <= 1'b1;
                col_r     <= '0;
                row_r     <= DIM_W'(h_eff);
                sum_r     <= '0;
                cnt_r     <= '0;
                quo_r     <= sum_r;
                rem_r     <= '0;
                divisor_r <= cnt_r;
                step_r    <= '0;
                if (cnt_r == '0) begin
                  mean_r  <= '0;
                  state_r <= S_FINISH;
                end else begin
                  state_r <= S_DIV;
                end
              end
              OP_BINARIZE: begin
                pix_r   <= (in_ch.data.gray_value < mean_r) ? '0 : PIX_WHITE;
                state_r <= S_FINISH;
              end
              default: begin
                pix_r   <= '0;
                state_r <= S_FINISH;
              end
            endcase
          end
        end
        S_LUMA: begin
          acc_r  <= acc_r + prod;
          step_r <= step_r + 1'b1;
          if (step_r == 5'd2) begin
            state_r <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          pix_r <= luma;
          if (col_in && row_in) begin
            col_r <= col_inc;
            sum_r <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            if (cnt_r != {CNT_W{1'b1}}) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end else if ((DIM_W+1)'(col_inc) == w_eff) begin
            col_r <= '0;
            row_r <= row_r - 1'b1;
          end else begin
            col_r <= col_inc;
          end
          state_r <= S_FINISH;
        end
        S_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == DivLast) begin
            mean_r  <= (quo_nxt[SUM_W-1:PIX_W] != '0) ? PIX_WHITE : quo_nxt[PIX_W-1:0];
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r           <= 1'b1;
            out_data_r.pixel_out  <= pix_r;
            out_data_r.mean_out   <= mean_r;
            out_data_r.mean_valid <= flag_r;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gcb_checker.sv
// Port-level checks for gray_convert_center_mean_binarize_top, bound to every instance.
// Depends on gcb_pkg for the result payload type.
`default_nettype none

module gcb_checker (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input gcb_pkg::gcb_out_t out_data
);
  import gcb_pkg::*;

  logic seen_mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_mean_r <= 1'b0;
    end else if (out_valid && out_ready && out_data.mean_valid) begin
      seen_mean_r <= 1'b1;
    end
  end

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // no mean before an end of frame
  a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mean_valid |-> out_data.mean_out == '0)
    else $error("nonzero mean without a latched frame");

  // the latched flag never clears without reset
  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_mean_r |-> out_data.mean_valid)
    else $error("mean_valid fell after being reported");

endmodule

bind gray_convert_center_mean_binarize_top gcb_checker u_gcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
